### hdl/skv_pkg.sv
// shared types and codes for the sorted key/value table
package skv_pkg;

   typedef enum logic [2:0] {
      ACT_SET     = 3'd0,
      ACT_GET     = 3'd1,
      ACT_DELETE  = 3'd2,
      ACT_CLEAR   = 3'd3,
      ACT_SIZE    = 3'd4,
      ACT_KEYS    = 3'd5,
      ACT_CLEANUP = 3'd6,
      ACT_TICK    = 3'd7
   } action_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_MISS     = 2'd1,
      ST_FULL     = 2'd2,
      ST_RESERVED = 2'd3
   } status_type;

   typedef struct packed {
      action_type  action;
      logic [63:0] item_key;
      logic [63:0] item_value;
      logic [15:0] lifetime;
   } req_word_type;

   typedef struct packed {
      status_type  status;
      logic [63:0] found_value;
      logic [63:0] listed_key;
      logic [5:0]  live_count;
      logic        last;
   } rsp_word_type;

   // one table entry as held in memory
   typedef struct packed {
      logic [63:0] key;
      logic [63:0] value;
      logic [31:0] expiry;
   } entry_type;

endpackage

### hdl/sorted_kv_table_with_ttl.sv
// top level of the sorted key/value table with expiry
//
// Usage: drive req_word and raise start while busy is low; the word is taken
// at that edge. Results come on rsp_word, each for one cycle with rsp_valid
// high; the receiver cannot hold them off. rsp_word.last marks an action's
// final result; busy drops in the cycle that this result is shown.
// All entries sit in one ram (one entry per address, registered read).
// Steps: a compacting sweep reads every stored entry once (read, then write
// back to its packed place unless expired). Binary search then makes up to
// log2(depth)+1 probes, each a ram read then a compare. An insert or delete
// shifts entries one at a time, each read and then written back. Keys reads
// each key and then emits it. Clear and tick skip the sweep.
// Reset: entry count and time go to zero and the ram contents are left
// undefined, since nothing past the entry count is ever read; the block is
// ready in the cycle after reset drops.
module sorted_kv_table_with_ttl
   import skv_pkg::*;
#(
   parameter int TABLE_DEPTH = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_word_type req_word,
   output logic         rsp_valid,
   output rsp_word_type rsp_word
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int EW = $bits(entry_type);

   typedef enum logic [3:0] {
      S_IDLE, S_SW_RD, S_SW_WR, S_SR_RD, S_SR_CMP, S_INS_RD, S_INS_WR,
      S_DEL_RD, S_DEL_WR, S_KEY_RD, S_KEY_OUT, S_DONE
   } state_type;

   state_type    state_ff;
   req_word_type req_ff;
   logic [CW-1:0] count_ff;
   logic [31:0]   now_ff;
   logic [CW-1:0] rd_idx_ff;   // sweep read index, shift index, key index
   logic [CW-1:0] wr_idx_ff;   // sweep compaction write index
   logic [CW-1:0] lo_ff, hi_ff, mid_ff;
   logic [31:0]   exp_ff;
   rsp_word_type  rsp_ff;
   logic          rsp_valid_ff;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   entry_type     wr_data, rd_data;

   skv_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // expiry of a new entry, saturated
   logic [32:0] exp_sum;
   assign exp_sum = {1'b0, now_ff} + {17'd0, req_word.lifetime};

   logic [CW-1:0] mid_calc;
   assign mid_calc = lo_ff + ((hi_ff - lo_ff) >> 1);

   logic rd_expired;
   assign rd_expired = (rd_data.expiry != 32'd0) && (rd_data.expiry <= now_ff);

   // ram port control
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = wr_idx_ff[AW-1:0];
      wr_data = rd_data;
      rd_addr = rd_idx_ff[AW-1:0];
      unique case (state_ff)
         S_SW_WR: begin
            wr_en = !rd_expired;
         end
         S_SR_RD: begin
            // probe address goes out with the midpoint being latched
            rd_addr = mid_calc[AW-1:0];
         end
         S_SR_CMP: begin
            // update in place on a set hit
            wr_en   = (req_ff.action == ACT_SET) && (rd_data.key == req_ff.item_key);
            wr_addr = mid_ff[AW-1:0];
            wr_data = '{key: rd_data.key, value: req_ff.item_value, expiry: exp_ff};
         end
         S_INS_RD: begin
            rd_addr = AW'(rd_idx_ff - 1'b1);
         end
         S_INS_WR: begin
            wr_en   = 1'b1;
            wr_addr = rd_idx_ff[AW-1:0];
            if (rd_idx_ff == lo_ff) begin
               wr_data = '{key: req_ff.item_key, value: req_ff.item_value, expiry: exp_ff};
            end
         end
         S_DEL_RD: begin
            rd_addr = AW'(rd_idx_ff + 1'b1);
         end
         S_DEL_WR: begin
            wr_en   = 1'b1;
            wr_addr = rd_idx_ff[AW-1:0];
         end
         default: begin
         end
      endcase
   end

   // control sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         now_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  req_ff    <= req_word;
                  exp_ff    <= (req_word.lifetime == 16'd0) ? 32'd0 :
                               (exp_sum[32] ? 32'hFFFF_FFFF : exp_sum[31:0]);
                  rd_idx_ff <= '0;
                  wr_idx_ff <= '0;
                  rsp_ff    <= '{status: ST_OK, found_value: '0, listed_key: '0,
                                 live_count: '0, last: 1'b1};
                  unique case (req_word.action)
                     ACT_CLEAR: begin
                        count_ff <= '0;
                        state_ff <= S_DONE;
                     end
                     ACT_TICK: begin
                        if (now_ff != 32'hFFFF_FFFF) now_ff <= now_ff + 32'd1;
                        state_ff <= S_DONE;
                     end
                     // every other action sweeps first; an empty table ends it at once
                     default: state_ff <= S_SW_RD;
                  endcase
               end
            end
            S_SW_RD: begin
               if (rd_idx_ff >= count_ff) begin
                  // sweep done, entry count is the compacted size
                  count_ff <= wr_idx_ff;
                  lo_ff    <= '0;
                  hi_ff    <= wr_idx_ff;
                  unique case (req_ff.action) inside
                     ACT_SET, ACT_GET, ACT_DELETE: state_ff <= S_SR_RD;
                     ACT_KEYS: begin
                        rd_idx_ff <= '0;
                        if (wr_idx_ff == '0) begin
                           rsp_ff.status <= ST_MISS;
                           state_ff      <= S_DONE;
                        end else begin
                           state_ff <= S_KEY_RD;
                        end
                     end
                     default: state_ff <= S_DONE;
                  endcase
               end else begin
                  state_ff <= S_SW_WR;
               end
            end
            S_SW_WR: begin
               if (!rd_expired && count_ff != '0) wr_idx_ff <= wr_idx_ff + 1'b1;
               rd_idx_ff <= rd_idx_ff + 1'b1;
               state_ff  <= S_SW_RD;
            end
            S_SR_RD: begin
               if (lo_ff < hi_ff) begin
                  mid_ff   <= mid_calc;
                  state_ff <= S_SR_CMP;
               end else begin
                  // miss, lo is the insertion point
                  unique case (req_ff.action)
                     ACT_SET: begin
                        if (count_ff >= CW'(TABLE_DEPTH)) begin
                           rsp_ff.status <= ST_FULL;
                           state_ff      <= S_DONE;
                        end else begin
                           rd_idx_ff <= count_ff;
                           state_ff  <= (count_ff == lo_ff) ? S_INS_WR : S_INS_RD;
                        end
                     end
                     default: begin
                        rsp_ff.status <= ST_MISS;
                        state_ff      <= S_DONE;
                     end
                  endcase
               end
            end
            S_SR_CMP: begin
               if (rd_data.key == req_ff.item_key) begin
                  unique case (req_ff.action)
                     ACT_GET: begin
                        rsp_ff.found_value <= rd_data.value;
                        state_ff           <= S_DONE;
                     end
                     ACT_DELETE: begin
                        rd_idx_ff <= mid_ff;
                        if (mid_ff + 1'b1 >= count_ff) begin
                           count_ff <= count_ff - 1'b1;
                           state_ff <= S_DONE;
                        end else begin
                           state_ff <= S_DEL_RD;
                        end
                     end
                     default: state_ff <= S_DONE;
                  endcase
               end else if (rd_data.key < req_ff.item_key) begin
                  lo_ff    <= mid_ff + 1'b1;
                  state_ff <= S_SR_RD;
               end else begin
                  hi_ff    <= mid_ff;
                  state_ff <= S_SR_RD;
               end
            end
            S_INS_RD: begin
               state_ff <= S_INS_WR;
            end
            S_INS_WR: begin
               if (rd_idx_ff == lo_ff) begin
                  count_ff <= count_ff + 1'b1;
                  state_ff <= S_DONE;
               end else begin
                  rd_idx_ff <= rd_idx_ff - 1'b1;
                  state_ff  <= (rd_idx_ff - 1'b1 == lo_ff) ? S_INS_WR : S_INS_RD;
               end
            end
            S_DEL_RD: begin
               state_ff <= S_DEL_WR;
            end
            S_DEL_WR: begin
               rd_idx_ff <= rd_idx_ff + 1'b1;
               if (rd_idx_ff + 2'd2 >= count_ff) begin
                  count_ff <= count_ff - 1'b1;
                  state_ff <= S_DONE;
               end else begin
                  state_ff <= S_DEL_RD;
               end
            end
            S_KEY_RD: begin
               state_ff <= S_KEY_OUT;
            end
            S_KEY_OUT: begin
               rsp_valid_ff <= 1'b1;
               rsp_ff.listed_key <= rd_data.key;
               rsp_ff.live_count <= 6'(count_ff);
               rsp_ff.last       <= (rd_idx_ff + 1'b1 == count_ff);
               rd_idx_ff         <= rd_idx_ff + 1'b1;
               state_ff <= (rd_idx_ff + 1'b1 == count_ff) ? S_IDLE : S_KEY_RD;
            end
            S_DONE: begin
               rsp_valid_ff      <= 1'b1;
               rsp_ff.live_count <= 6'(count_ff);
               rsp_ff.last       <= 1'b1;
               state_ff          <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

`ifndef NO_ASSERTIONS
   // entry count never passes the depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_DEPTH))
      else $error("entry count above depth");

   // an accepted word always makes the block busy next cycle
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("start not taken");

   // a final result returns the block to idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.last) |-> !busy)
      else $error("busy after final result");

   // time never moves backwards
   a_time_mono: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) |-> now_ff >= $past(now_ff))
      else $error("time counter went back");
`endif

endmodule

### hdl/skv_ram.sv
// generic single-port-write, single-port-read ram with registered read
module skv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

### dv/sorted_kv_table_with_ttl_test.sv
// self-checking testbench for the sorted key/value table with expiry
module sorted_kv_table_with_ttl_test
   import skv_pkg::*;
();

   localparam int DEPTH = 32;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   req_word_type req_word = '0;
   logic         rsp_valid;
   rsp_word_type rsp_word;
   logic [223:0] noise;

   sorted_kv_table_with_ttl #(.TABLE_DEPTH(DEPTH)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_word(req_word), .rsp_valid(rsp_valid), .rsp_word(rsp_word)
   );

   always #1 clock = ~clock;

   // predictor state
   logic [63:0] tbl_key [DEPTH];
   logic [63:0] tbl_val [DEPTH];
   logic [31:0] tbl_exp [DEPTH];
   int          tbl_count = 0;
   logic [31:0] now_tick = 0;

   req_word_type pending_words [$];
   rsp_word_type expected_rsps [$];
   int  send_idle_pct = 0;
   bit  hold_send = 0;
   bit  stim_done = 0;
   int  errors = 0;
   int  sent = 0;

   function automatic rsp_word_type mk(status_type s, logic [63:0] v, logic [63:0] k,
                                       bit l);
      rsp_word_type r;
      r.status = s; r.found_value = v; r.listed_key = k;
      r.live_count = tbl_count[5:0]; r.last = l;
      return r;
   endfunction

   // drop entry at position p, closing the gap
   function automatic void drop_at(int p);
      for (int j = p; j + 1 < tbl_count; j++) begin
         tbl_key[j] = tbl_key[j+1]; tbl_val[j] = tbl_val[j+1]; tbl_exp[j] = tbl_exp[j+1];
      end
      tbl_count--;
   endfunction

   function automatic void purge_expired();
      int i;
      i = 0;
      while (i < tbl_count) begin
         if (tbl_exp[i] != 0 && tbl_exp[i] <= now_tick) drop_at(i);
         else i++;
      end
   endfunction

   // binary search: returns hit, pos is hit or insertion point
   function automatic bit lookup(logic [63:0] k, output int pos);
      int lo, hi, mid;
      lo = 0; hi = tbl_count;
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (tbl_key[mid] == k) begin
            pos = mid; return 1;
         end
         if (tbl_key[mid] < k) lo = mid + 1;
         else hi = mid;
      end
      pos = lo;
      return 0;
   endfunction

   function automatic void predict_table(req_word_type w);
      int pos;
      logic [32:0] sum;
      logic [31:0] ex;
      case (w.action)
         ACT_SET: begin
            ex = 0;
            if (w.lifetime != 0) begin
               sum = {1'b0, now_tick} + w.lifetime;
               ex = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            end
            purge_expired();
            if (lookup(w.item_key, pos)) begin
               tbl_val[pos] = w.item_value; tbl_exp[pos] = ex;
               expected_rsps.push_back(mk(ST_OK, 0, 0, 1));
            end else if (tbl_count >= DEPTH) begin
               expected_rsps.push_back(mk(ST_FULL, 0, 0, 1));
            end else begin
               for (int i = tbl_count; i > pos; i--) begin
                  tbl_key[i] = tbl_key[i-1]; tbl_val[i] = tbl_val[i-1];
                  tbl_exp[i] = tbl_exp[i-1];
               end
               tbl_key[pos] = w.item_key; tbl_val[pos] = w.item_value; tbl_exp[pos] = ex;
               tbl_count++;
               expected_rsps.push_back(mk(ST_OK, 0, 0, 1));
            end
         end
         ACT_GET: begin
            purge_expired();
            if (lookup(w.item_key, pos))
               expected_rsps.push_back(mk(ST_OK, tbl_val[pos], 0, 1));
            else expected_rsps.push_back(mk(ST_MISS, 0, 0, 1));
         end
         ACT_DELETE: begin
            purge_expired();
            if (lookup(w.item_key, pos)) begin
               drop_at(pos);
               expected_rsps.push_back(mk(ST_OK, 0, 0, 1));
            end else expected_rsps.push_back(mk(ST_MISS, 0, 0, 1));
         end
         ACT_CLEAR: begin
            tbl_count = 0;
            expected_rsps.push_back(mk(ST_OK, 0, 0, 1));
         end
         ACT_KEYS: begin
            purge_expired();
            if (tbl_count == 0) expected_rsps.push_back(mk(ST_MISS, 0, 0, 1));
            for (int i = 0; i < tbl_count; i++)
               expected_rsps.push_back(mk(ST_OK, 0, tbl_key[i], i + 1 == tbl_count));
         end
         ACT_TICK: begin
            if (now_tick != 32'hFFFF_FFFF) now_tick++;
            expected_rsps.push_back(mk(ST_OK, 0, 0, 1));
         end
         default: begin
            purge_expired();
            expected_rsps.push_back(mk(ST_OK, 0, 0, 1));
         end
      endcase
   endfunction

   // driver: one word per accepted start
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            predict_table(req_word);
            sent++;
         end
         if (start && busy) begin
            // hold the word
         end else if (!hold_send && pending_words.size() > 0 &&
                      $urandom_range(99, 0) >= send_idle_pct) begin
            req_word <= pending_words.pop_front();
            start    <= 1'b1;
         end else begin
            start    <= 1'b0;
            noise     = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom};
            req_word <= noise[$bits(req_word_type)-1:0];
         end
      end
   end

   // monitor: compare each strobed word with the oldest expectation
   always @(posedge clock) begin
      rsp_word_type e;
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            $error("unexpected response word %h", rsp_word);
            errors++;
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_word.status !== e.status) begin
               $error("status exp %0d got %0d", e.status, rsp_word.status); errors++;
            end
            if (rsp_word.found_value !== e.found_value) begin
               $error("found_value exp %h got %h", e.found_value, rsp_word.found_value);
               errors++;
            end
            if (rsp_word.listed_key !== e.listed_key) begin
               $error("listed_key exp %h got %h", e.listed_key, rsp_word.listed_key);
               errors++;
            end
            if (rsp_word.live_count !== e.live_count) begin
               $error("live_count exp %0d got %0d", e.live_count, rsp_word.live_count);
               errors++;
            end
            if (rsp_word.last !== e.last) begin
               $error("last exp %0d got %0d", e.last, rsp_word.last); errors++;
            end
         end
      end
   end

   function automatic req_word_type word_of(action_type a, logic [63:0] k,
                                            logic [63:0] v, logic [15:0] l);
      req_word_type w;
      w.action = a; w.item_key = k; w.item_value = v; w.lifetime = l;
      return w;
   endfunction

   function automatic logic [63:0] rnd64();
      return {$urandom, $urandom};
   endfunction

   // keys drawn mostly from a small pool so that hits are frequent
   function automatic logic [63:0] pool_key();
      case ($urandom_range(3, 0))
         0: return 64'(($urandom_range(39, 0)));
         1: return 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(7, 0);
         2: return {2'($urandom_range(3, 0)), 30'h0, 32'h0} |
                   64'($urandom_range(15, 0));
         default: return rnd64();
      endcase
   endfunction

   function automatic req_word_type rnd_word();
      int r;
      logic [15:0] l;
      r = $urandom_range(99, 0);
      l = ($urandom_range(1, 0)) ? 16'(($urandom_range(6, 0))) : 16'($urandom);
      if (r < 40) return word_of(ACT_SET, pool_key(), rnd64(), l);
      if (r < 60) return word_of(ACT_GET, pool_key(), rnd64(), 16'($urandom));
      if (r < 70) return word_of(ACT_DELETE, pool_key(), rnd64(), 16'($urandom));
      if (r < 82) return word_of(ACT_TICK, rnd64(), rnd64(), 16'($urandom));
      if (r < 88) return word_of(ACT_KEYS, rnd64(), rnd64(), 16'($urandom));
      if (r < 93) return word_of(ACT_SIZE, rnd64(), rnd64(), 16'($urandom));
      if (r < 98) return word_of(ACT_CLEANUP, rnd64(), rnd64(), 16'($urandom));
      return word_of(ACT_CLEAR, rnd64(), rnd64(), 16'($urandom));
   endfunction

   task automatic drain_all();
      while (pending_words.size() > 0 || start || busy || expected_rsps.size() > 0)
         @(posedge clock);
   endtask

   // stimulus
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 11;
      // directed: empty table cases, extremes, expiry, full table
      pending_words.push_back(word_of(ACT_KEYS, 0, 0, 0));
      pending_words.push_back(word_of(ACT_GET, 0, 0, 0));
      pending_words.push_back(word_of(ACT_DELETE, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0));
      pending_words.push_back(word_of(ACT_SET, 64'hFFFF_FFFF_FFFF_FFFF,
                                      64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF));
      pending_words.push_back(word_of(ACT_SET, 0, 0, 0));
      pending_words.push_back(word_of(ACT_SET, 64'h8000_0000_0000_0000, 64'h5A5A, 2));
      pending_words.push_back(word_of(ACT_GET, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0));
      pending_words.push_back(word_of(ACT_KEYS, 0, 0, 0));
      pending_words.push_back(word_of(ACT_TICK, 0, 0, 0));
      pending_words.push_back(word_of(ACT_TICK, 0, 0, 0));
      pending_words.push_back(word_of(ACT_SIZE, 0, 0, 0));
      pending_words.push_back(word_of(ACT_GET, 64'h8000_0000_0000_0000, 0, 0));
      pending_words.push_back(word_of(ACT_SET, 0, 64'h1234, 1));
      pending_words.push_back(word_of(ACT_TICK, 0, 0, 0));
      pending_words.push_back(word_of(ACT_CLEANUP, 0, 0, 0));
      pending_words.push_back(word_of(ACT_DELETE, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0));
      pending_words.push_back(word_of(ACT_CLEAR, 0, 0, 0));
      for (int i = 0; i < DEPTH; i++)
         pending_words.push_back(word_of(ACT_SET, 64'(DEPTH - i) * 3, rnd64(), 0));
      pending_words.push_back(word_of(ACT_SET, 64'd7, 1, 0));
      pending_words.push_back(word_of(ACT_SET, 64'd9, 64'hBEEF, 0));
      pending_words.push_back(word_of(ACT_KEYS, 0, 0, 0));
      pending_words.push_back(word_of(ACT_CLEAR, 0, 0, 0));
      drain_all();
      // sender held off after everything outstanding is done
      hold_send = 1;
      repeat (20) @(posedge clock);
      hold_send = 0;
      for (int n = 0; n < 167; n++) begin
         if (n == 56) begin
            drain_all();
            send_idle_pct = 84;
         end
         if (n == 112) begin
            drain_all();
            send_idle_pct = 0;
         end
         pending_words.push_back(rnd_word());
      end
      drain_all();
      repeat (250) @(posedge clock);
      if (errors == 0 && expected_rsps.size() == 0) $display("[sorted_kv_table_with_ttl] OK");
      else $display("[sorted_kv_table_with_ttl] ERROR");
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("[sorted_kv_table_with_ttl] ERROR");
      $finish;
   end

endmodule
